### hw/rtl/multi_channel_release_timer_defines.svh
// Assertion macros used by the release timer channel RTL.
`ifndef MULTI_CHANNEL_RELEASE_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_RELEASE_TIMER_DEFINES_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define MCRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mcrt assertion failed");

// cond must never be seen outside reset
`define MCRT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mcrt forbidden condition seen");

`else

`define MCRT_ASSERT(lbl, clk, rst_n, prop)
`define MCRT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### hw/rtl/mcrt_pkg.sv
// Types and constants of the multi-channel release timer.
package mcrt_pkg;

  localparam int unsigned DURATION_WIDTH = 32;
  localparam int unsigned HOLD_W         = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [HOLD_W-1:0] SWITCH_HOLD_RESET = 16'd500;
  localparam logic [HOLD_W-1:0] RING_HOLD_RESET   = 16'd3000;
  localparam logic [HOLD_W-1:0] MOTION_HOLD_RESET = 16'd200;

  // register index, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_SWITCH_HOLD = 2'd0,
    REG_RING_HOLD   = 2'd1,
    REG_MOTION_HOLD = 2'd2
  } mcrt_reg_e;

  localparam int unsigned CH_SWITCH = 0;
  localparam int unsigned CH_RING   = 1;
  localparam int unsigned CH_MOTION = 2;

  typedef struct packed {
    logic accept;
    logic start;
    logic level;
  } chan_ctrl_t;

  typedef struct packed {
    logic                      ended;
    logic                      active;
    logic [DURATION_WIDTH-1:0] duration;
  } chan_stat_t;

endpackage

### hw/rtl/mcrt_channel.sv
// One release channel: arm, duration count, hold count and end detection.
`include "multi_channel_release_timer_defines.svh"

module mcrt_channel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcrt_pkg::chan_ctrl_t          ctrl_i,
  input  logic [mcrt_pkg::HOLD_W-1:0]   hold_ticks_i,
  output mcrt_pkg::chan_stat_t          stat_o
);
  import mcrt_pkg::*;

  logic                      active_q, active_d;
  logic [HOLD_W-1:0]         hold_q, hold_d;
  logic [DURATION_WIDTH-1:0] dur_q, dur_d;
  logic                      ended;

  logic                      armed;
  logic [HOLD_W-1:0]         hold_inc;
  logic [DURATION_WIDTH-1:0] dur_inc;

  always_comb begin
    armed    = active_q | ctrl_i.start;
    dur_inc  = (ctrl_i.start ? '0 : dur_q) + DURATION_WIDTH'(1);
    hold_inc = (ctrl_i.start ? '0 : hold_q) + HOLD_W'(1);
    active_d = active_q;
    hold_d   = hold_q;
    dur_d    = dur_q;
    ended    = 1'b0;
    if (armed) begin
      active_d = 1'b1;
      dur_d    = dur_inc;
      if (ctrl_i.level) begin
        hold_d = '0;
      end else if (hold_inc == hold_ticks_i) begin
        // released: drop the trailing hold from the duration
        active_d = 1'b0;
        hold_d   = '0;
        dur_d    = dur_inc - DURATION_WIDTH'(hold_ticks_i);
        ended    = 1'b1;
      end else begin
        hold_d = hold_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      hold_q   <= '0;
      dur_q    <= '0;
    end else if (ctrl_i.accept) begin
      active_q <= active_d;
      hold_q   <= hold_d;
      dur_q    <= dur_d;
    end
  end

  assign stat_o.ended    = ended;
  assign stat_o.active   = active_d;
  assign stat_o.duration = dur_d;

  `MCRT_NEVER(a_idle_hold_zero, clk_i, rst_ni, !active_q && (hold_q != '0))
  `MCRT_ASSERT(a_end_needs_absent, clk_i, rst_ni, ended |-> (armed && !ctrl_i.level))
  `MCRT_ASSERT(a_end_disarms, clk_i, rst_ni, (ctrl_i.accept && ended) |=> !active_q)
  `MCRT_ASSERT(a_level_clears_hold, clk_i, rst_ni,
               (ctrl_i.accept && armed && ctrl_i.level) |=> (active_q && (hold_q == '0)))

endmodule

### hw/rtl/multi_channel_release_timer.sv
// Top level of the multi-channel release timer.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | to block  | in_valid_i / in_stall_o    | levels, starts, buzzer/siren time
//   out     | from block| out_valid_o / out_stall_i  | end events, durations, flags, millis
//   cfg     | to block  | APB psel/penable/pready    | three 16-bit hold registers
//
// One tick per cycle unless the input stalls; the update is combinational
// from the input ports and state registers into the result register.
// The input stalls only while a result waits and the output stalls.
// Reset clears all counters and loads the hold registers with defaults;
// there is no clearing pass.

module multi_channel_release_timer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input tick
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              switch_level_i,
  input  logic                              ring_level_i,
  input  logic                              motion_level_i,
  input  logic                              switch_start_i,
  input  logic                              ring_start_i,
  input  logic                              motion_start_i,
  input  logic                              buzzer_start_i,
  input  logic signed [mcrt_pkg::TIME_W-1:0] buzzer_time_i,
  input  logic                              siren_start_i,
  input  logic signed [mcrt_pkg::TIME_W-1:0] siren_time_i,
  // result
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        end_events_o,
  output logic [31:0]                       switch_duration_o,
  output logic [31:0]                       ring_elapsed_o,
  output logic [31:0]                       motion_duration_o,
  output logic [4:0]                        active_flags_o,
  output logic [31:0]                       millis_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcrt_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mcrt_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mcrt_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import mcrt_pkg::*;

  typedef struct packed {
    logic              on;
    logic [TIME_W-1:0] left;
  } timer_t;

  function automatic timer_t step_timer(timer_t t);
    timer_t r;
    r = t;
    if (t.on && !t.left[TIME_W-1]) begin
      r.left = t.left - TIME_W'(1);
      if ((r.left == '0) || r.left[TIME_W-1]) begin
        r.on = 1'b0;
      end
    end
    return r;
  endfunction

  logic              accept;
  logic              cfg_we;
  mcrt_reg_e         cfg_idx;
  logic [HOLD_W-1:0] hold_q [NUM_CH];

  logic [31:0]       tick_q, tick_d;
  timer_t            buzzer_q, buzzer_d, siren_q, siren_d;
  timer_t            buzzer_pre, siren_pre;

  chan_ctrl_t        ctrl [NUM_CH];
  chan_stat_t        stat [NUM_CH];
  logic [NUM_CH-1:0] starts, levels;

  logic              out_valid_q;
  logic [2:0]        end_events_q;
  logic [31:0]       switch_dur_q, ring_dur_q, motion_dur_q, millis_q;
  logic [4:0]        flags_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = mcrt_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q[CH_SWITCH] <= SWITCH_HOLD_RESET;
      hold_q[CH_RING]   <= RING_HOLD_RESET;
      hold_q[CH_MOTION] <= MOTION_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SWITCH_HOLD: hold_q[CH_SWITCH] <= pwdata[HOLD_W-1:0];
        REG_RING_HOLD:   hold_q[CH_RING]   <= pwdata[HOLD_W-1:0];
        REG_MOTION_HOLD: hold_q[CH_MOTION] <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SWITCH_HOLD: prdata = APB_DATA_W'(hold_q[CH_SWITCH]);
      REG_RING_HOLD:   prdata = APB_DATA_W'(hold_q[CH_RING]);
      REG_MOTION_HOLD: prdata = APB_DATA_W'(hold_q[CH_MOTION]);
      default:         prdata = '0;
    endcase
  end

  // channels
  assign starts = {motion_start_i, ring_start_i, switch_start_i};
  assign levels = {motion_level_i, ring_level_i, switch_level_i};

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    assign ctrl[c].accept = accept;
    assign ctrl[c].start  = starts[c];
    assign ctrl[c].level  = levels[c];

    mcrt_channel u_chan (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[c]),
      .hold_ticks_i (hold_q[c]),
      .stat_o       (stat[c])
    );
  end

  // millis, buzzer and siren
  always_comb begin
    tick_d     = tick_q + 32'd1;
    buzzer_pre = buzzer_q;
    if (buzzer_start_i) begin
      buzzer_pre.on   = 1'b1;
      buzzer_pre.left = buzzer_time_i;
    end
    // motion release silences the buzzer, remaining time is kept
    if (stat[CH_MOTION].ended) begin
      buzzer_pre.on = 1'b0;
    end
    siren_pre = siren_q;
    if (siren_start_i) begin
      siren_pre.on   = 1'b1;
      siren_pre.left = siren_time_i;
    end
    buzzer_d = step_timer(buzzer_pre);
    siren_d  = step_timer(siren_pre);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      buzzer_q <= '0;
      siren_q  <= '0;
    end else if (accept) begin
      tick_q   <= tick_d;
      buzzer_q <= buzzer_d;
      siren_q  <= siren_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      end_events_q <= {stat[CH_MOTION].ended, stat[CH_RING].ended, stat[CH_SWITCH].ended};
      switch_dur_q <= 32'(stat[CH_SWITCH].duration);
      ring_dur_q   <= 32'(stat[CH_RING].duration);
      motion_dur_q <= 32'(stat[CH_MOTION].duration);
      flags_q      <= {siren_d.on, buzzer_d.on, stat[CH_MOTION].active,
                       stat[CH_RING].active, stat[CH_SWITCH].active};
      millis_q     <= tick_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign end_events_o      = end_events_q;
  assign switch_duration_o = switch_dur_q;
  assign ring_elapsed_o    = ring_dur_q;
  assign motion_duration_o = motion_dur_q;
  assign active_flags_o    = flags_q;
  assign millis_o          = millis_q;

endmodule

### test/multi_channel_release_timer_tb.sv
// Self-checking testbench for the multi-channel release timer.
`timescale 1ns / 1ps

module multi_channel_release_timer_tb;
  import mcrt_pkg::*;

  localparam int          HALF_PERIOD    = 6;
  localparam int          CLK_PERIOD     = 2 * HALF_PERIOD;
  localparam int          RESET_CYCLES   = 8;
  localparam int          TIMEOUT_CYCLES = 1_000_000;
  localparam int          TAIL_CYCLES    = 8;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          SQUEEZE_CYCLES = 250;
  localparam int          NUM_PHASES     = 8;
  localparam int          PHASE_ITEMS    = 244;
  localparam int          FULL_HOLD_PHASE = 2;
  localparam int          WRAP_HOLD_PHASE = 3;
  localparam int          CALM_PHASE     = 1;
  localparam int          SQUEEZE_PHASE  = 5;
  localparam int          MAX_REPORTS    = 40;
  localparam int unsigned REG_BYTES      = 4;
  localparam int unsigned SPARE_REG_IDX  = 3;  // decodes to no register
  localparam int          PLAN_LEN       = 22;

  typedef struct packed {
    logic [2:0]  level;      // bit0 switch, bit1 ring, bit2 motion
    logic [2:0]  start;
    logic        buzz_go;
    logic [31:0] buzz_time;
    logic        siren_go;
    logic [31:0] siren_time;
  } tick_in_t;

  typedef struct packed {
    logic [2:0]  ends;
    logic [31:0] switch_dur;
    logic [31:0] ring_dur;
    logic [31:0] motion_dur;
    logic [4:0]  flags;
    logic [31:0] millis;
  } tick_out_t;

  typedef struct {
    tick_in_t  stim;
    bit        typed;
    tick_out_t want;
  } plan_row_t;

  localparam tick_out_t NO_WANT = '0;

  // holds during the table: switch 1, ring 2, motion 3
  plan_row_t plan [PLAN_LEN] = '{
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b1,
      '{3'b000, 32'd0, 32'd0, 32'd0, 5'b00000, 32'd1}},
    '{'{3'b000, 3'b000, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000}, 1'b1,
      '{3'b000, 32'd0, 32'd0, 32'd0, 5'b11000, 32'd2}},
    '{'{3'b111, 3'b111, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b1,
      '{3'b000, 32'd1, 32'd1, 32'd1, 5'b11111, 32'd3}},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b100, 3'b100, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b1, 32'd5, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b1, 32'd0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b1, 32'd1}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b1, 32'd2}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b1, 32'd0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b011, 3'b011, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b001, 3'b001, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b010, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b111, 3'b000, 1'b1, 32'd3, 1'b1, 32'hFFFF_FFFB}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b010, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT},
    '{'{3'b111, 3'b111, 1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF}, 1'b0, NO_WANT},
    '{'{3'b000, 3'b000, 1'b0, 32'h0, 1'b0, 32'h0}, 1'b0, NO_WANT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     switch_level_i;
  logic                     ring_level_i;
  logic                     motion_level_i;
  logic                     switch_start_i;
  logic                     ring_start_i;
  logic                     motion_start_i;
  logic                     buzzer_start_i;
  logic signed [TIME_W-1:0] buzzer_time_i;
  logic                     siren_start_i;
  logic signed [TIME_W-1:0] siren_time_i;

  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  end_events_o;
  logic [31:0] switch_duration_o;
  logic [31:0] ring_elapsed_o;
  logic [31:0] motion_duration_o;
  logic [4:0]  active_flags_o;
  logic [31:0] millis_o;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  logic [31:0]       millis_cnt;
  logic [NUM_CH-1:0] ch_on;
  logic [15:0]       ch_hold [NUM_CH];
  logic [31:0]       ch_dur [NUM_CH];
  logic              bz_on;
  logic [31:0]       bz_left;
  logic              sr_on;
  logic [31:0]       sr_left;
  logic [15:0]       hold_cfg [NUM_CH];

  tick_out_t   predicted_outs [$];
  int          mismatch_count;
  int          ticks_sent;
  int          results_checked;
  int          hold_writes;
  int          ends_seen [NUM_CH];
  bit          calm;
  bit          squeeze_req;
  logic [2:0]  lvl_now;

  multi_channel_release_timer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .switch_level_i    (switch_level_i),
    .ring_level_i      (ring_level_i),
    .motion_level_i    (motion_level_i),
    .switch_start_i    (switch_start_i),
    .ring_start_i      (ring_start_i),
    .motion_start_i    (motion_start_i),
    .buzzer_start_i    (buzzer_start_i),
    .buzzer_time_i     (buzzer_time_i),
    .siren_start_i     (siren_start_i),
    .siren_time_i      (siren_time_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .end_events_o      (end_events_o),
    .switch_duration_o (switch_duration_o),
    .ring_elapsed_o    (ring_elapsed_o),
    .motion_duration_o (motion_duration_o),
    .active_flags_o    (active_flags_o),
    .millis_o          (millis_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout: %0d results still pending", predicted_outs.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_run_time();
    case ($urandom_range(0, 7))
      4: return 0 - $urandom_range(1, 5000);
      5: return $urandom();
      6: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      7: return $urandom_range(41, 400);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic void count_down(inout logic on, inout logic [31:0] left);
    if (on && !left[31]) begin
      left = left - 1;
      if (left == 0 || left[31]) on = 1'b0;
    end
  endfunction

  // one millisecond tick: starts, counter, channels, then buzzer and siren
  function automatic tick_out_t advance_timers(tick_in_t t);
    tick_out_t  r;
    logic [2:0] ended;
    ended = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (t.start[c]) begin
        ch_on[c]   = 1'b1;
        ch_dur[c]  = '0;
        ch_hold[c] = '0;
      end
    end
    if (t.buzz_go) begin
      bz_on   = 1'b1;
      bz_left = t.buzz_time;
    end
    if (t.siren_go) begin
      sr_on   = 1'b1;
      sr_left = t.siren_time;
    end
    millis_cnt = millis_cnt + 1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (ch_on[c]) begin
        ch_dur[c] = ch_dur[c] + 1;
        if (t.level[c]) begin
          ch_hold[c] = '0;
        end else begin
          ch_hold[c] = ch_hold[c] + 16'd1;  // wraps at 16 bits
          if (ch_hold[c] == hold_cfg[c]) begin
            ch_on[c]   = 1'b0;
            ch_hold[c] = '0;
            ch_dur[c]  = ch_dur[c] - {16'b0, hold_cfg[c]};
            ended[c]   = 1'b1;
            if (c == CH_MOTION) bz_on = 1'b0;
          end
        end
      end
    end
    count_down(bz_on, bz_left);
    count_down(sr_on, sr_left);
    r.ends       = ended;
    r.switch_dur = ch_dur[CH_SWITCH];
    r.ring_dur   = ch_dur[CH_RING];
    r.motion_dur = ch_dur[CH_MOTION];
    r.flags      = {sr_on, bz_on, ch_on[CH_MOTION], ch_on[CH_RING], ch_on[CH_SWITCH]};
    r.millis     = millis_cnt;
    return r;
  endfunction

  task automatic apb_xfer(input bit wr, input int unsigned idx,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(idx * REG_BYTES);
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_hold(input int unsigned idx);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd[15:0] !== hold_cfg[idx])
      note_mismatch("hold register readback", rd, 32'(hold_cfg[idx]));
  endtask

  task automatic set_hold(input int unsigned idx, input logic [31:0] data);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, data, rd);
    hold_writes++;
    if (idx < NUM_CH) begin
      hold_cfg[idx] = data[15:0];  // upper bits are dropped
      check_hold(idx);
    end
  endtask

  task automatic send_tick(input tick_in_t t, input bit typed, input tick_out_t want);
    tick_out_t pred;
    int        gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    switch_level_i <= t.level[CH_SWITCH];
    ring_level_i   <= t.level[CH_RING];
    motion_level_i <= t.level[CH_MOTION];
    switch_start_i <= t.start[CH_SWITCH];
    ring_start_i   <= t.start[CH_RING];
    motion_start_i <= t.start[CH_MOTION];
    buzzer_start_i <= t.buzz_go;
    buzzer_time_i  <= t.buzz_time;
    siren_start_i  <= t.siren_go;
    siren_time_i   <= t.siren_time;
    do @(posedge clk_i); while (in_stall_o);
    pred = advance_timers(t);
    predicted_outs.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (predicted_outs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int len;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        len = SQUEEZE_CYCLES;
      end else begin
        len = calm ? 0 : pick_gap();
      end
      if (len == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    tick_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_outs.size() == 0) begin
        note_mismatch("result with nothing pending", millis_o, '0);
      end else begin
        want = predicted_outs.pop_front();
        if (end_events_o !== want.ends)
          note_mismatch("end_events", 32'(end_events_o), 32'(want.ends));
        if (switch_duration_o !== want.switch_dur)
          note_mismatch("switch_duration", switch_duration_o, want.switch_dur);
        if (ring_elapsed_o !== want.ring_dur)
          note_mismatch("ring_elapsed", ring_elapsed_o, want.ring_dur);
        if (motion_duration_o !== want.motion_dur)
          note_mismatch("motion_duration", motion_duration_o, want.motion_dur);
        if (active_flags_o !== want.flags)
          note_mismatch("active_flags", 32'(active_flags_o), 32'(want.flags));
        if (millis_o !== want.millis)
          note_mismatch("millis", millis_o, want.millis);
        for (int c = 0; c < NUM_CH; c++)
          if (want.ends[c]) ends_seen[c]++;
        results_checked++;
      end
    end
  end

  initial begin
    tick_in_t    t;
    logic [31:0] word;
    logic [15:0] hv;
    int          flip_pct;
    int          start_pct;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    switch_level_i = 1'b0;
    ring_level_i   = 1'b0;
    motion_level_i = 1'b0;
    switch_start_i = 1'b0;
    ring_start_i   = 1'b0;
    motion_start_i = 1'b0;
    buzzer_start_i = 1'b0;
    buzzer_time_i  = '0;
    siren_start_i  = 1'b0;
    siren_time_i   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    squeeze_req    = 1'b0;
    lvl_now        = '0;

    millis_cnt = '0;
    ch_on      = '0;
    bz_on      = 1'b0;
    bz_left    = '0;
    sr_on      = 1'b0;
    sr_left    = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_hold[c]   = '0;
      ch_dur[c]    = '0;
      ends_seen[c] = 0;
    end
    hold_cfg[CH_SWITCH] = SWITCH_HOLD_RESET;
    hold_cfg[CH_RING]   = RING_HOLD_RESET;
    hold_cfg[CH_MOTION] = MOTION_HOLD_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_CH; i++) check_hold(i);

    // short holds so the table sees every channel end
    set_hold(REG_SWITCH_HOLD, 32'd1);
    set_hold(REG_RING_HOLD, 32'd2);
    set_hold(REG_MOTION_HOLD, 32'd3);
    for (int i = 0; i < PLAN_LEN; i++) send_tick(plan[i].stim, plan[i].typed, plan[i].want);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (p == FULL_HOLD_PHASE) hv = 16'hFFFF;
        else if (p == WRAP_HOLD_PHASE && i == CH_SWITCH) hv = 16'h0000;
        else hv = 16'($urandom_range(1, (p == 0) ? 8 : 24));
        word = $urandom();
        set_hold(mcrt_reg_e'(i), {word[31:16], hv});
      end
      set_hold(SPARE_REG_IDX, $urandom());

      flip_pct    = $urandom_range(8, 30);
      start_pct   = $urandom_range(2, 6);
      calm        = (p == CALM_PHASE || p == SQUEEZE_PHASE);
      squeeze_req = (p == SQUEEZE_PHASE);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // levels move in runs so channels see real release intervals
        for (int c = 0; c < NUM_CH; c++) begin
          if ($urandom_range(0, 99) < flip_pct) lvl_now[c] = ~lvl_now[c];
          t.start[c] = ($urandom_range(0, 99) < start_pct);
        end
        t.level      = lvl_now;
        t.buzz_go    = ($urandom_range(0, 99) < 6);
        t.buzz_time  = pick_run_time();
        t.siren_go   = ($urandom_range(0, 99) < 6);
        t.siren_time = pick_run_time();
        send_tick(t, 1'b0, NO_WANT);
      end
      drain();
    end

    calm = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted_outs.size() != 0)
      note_mismatch("results never delivered", predicted_outs.size(), '0);

    $display("covered %0d ticks over %0d hold settings, %0d results compared",
             ticks_sent, hold_writes, results_checked);
    $display("releases seen: switch %0d, ring %0d, motion %0d; %0d mismatches",
             ends_seen[CH_SWITCH], ends_seen[CH_RING], ends_seen[CH_MOTION],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
